FILE: rtl/tekd_pkg.sv
// Package with key codes, character constants and the classification function of the key decoder.
package tekd_pkg;

  localparam int unsigned KeyW = 5;
  typedef logic [KeyW-1:0] key_code_t;
  typedef logic [7:0]      byte_t;
  typedef logic [2:0]      len_t;

  localparam key_code_t KC_INVALID      = 5'd0;
  localparam key_code_t KC_INCOMPLETE   = 5'd1;
  localparam key_code_t KC_ESC          = 5'd2;
  localparam key_code_t KC_UP           = 5'd3;
  localparam key_code_t KC_DOWN         = 5'd4;
  localparam key_code_t KC_RIGHT        = 5'd5;
  localparam key_code_t KC_LEFT         = 5'd6;
  localparam key_code_t KC_HOME         = 5'd7;
  localparam key_code_t KC_END          = 5'd8;
  localparam key_code_t KC_SHIFT_TAB    = 5'd9;
  localparam key_code_t KC_F1           = 5'd10;
  localparam key_code_t KC_F2           = 5'd11;
  localparam key_code_t KC_F3           = 5'd12;
  localparam key_code_t KC_F4           = 5'd13;
  localparam key_code_t KC_F5           = 5'd14;
  localparam key_code_t KC_F6           = 5'd15;
  localparam key_code_t KC_F7           = 5'd16;
  localparam key_code_t KC_F8           = 5'd17;
  localparam key_code_t KC_F9           = 5'd18;
  localparam key_code_t KC_F10          = 5'd19;
  localparam key_code_t KC_F11          = 5'd20;
  localparam key_code_t KC_F12          = 5'd21;
  localparam key_code_t KC_INSERT       = 5'd22;
  localparam key_code_t KC_DELETE       = 5'd23;
  localparam key_code_t KC_PGUP         = 5'd24;
  localparam key_code_t KC_PGDN         = 5'd25;
  localparam key_code_t KC_SHIFT_RIGHT  = 5'd26;
  localparam key_code_t KC_SHIFT_LEFT   = 5'd27;
  localparam key_code_t KC_SHIFT_DELETE = 5'd28;

  localparam byte_t CH_ESC   = 8'h1B;
  localparam byte_t CH_LBRK  = 8'h5B;  // '['
  localparam byte_t CH_O     = 8'h4F;
  localparam byte_t CH_TILDE = 8'h7E;
  localparam byte_t CH_SEMI  = 8'h3B;
  localparam byte_t CH_A     = 8'h41;
  localparam byte_t CH_B     = 8'h42;
  localparam byte_t CH_C     = 8'h43;
  localparam byte_t CH_D     = 8'h44;
  localparam byte_t CH_F     = 8'h46;
  localparam byte_t CH_H     = 8'h48;
  localparam byte_t CH_P     = 8'h50;
  localparam byte_t CH_Q     = 8'h51;
  localparam byte_t CH_R     = 8'h52;
  localparam byte_t CH_S     = 8'h53;
  localparam byte_t CH_Z     = 8'h5A;
  localparam byte_t CH_0     = 8'h30;
  localparam byte_t CH_1     = 8'h31;
  localparam byte_t CH_2     = 8'h32;
  localparam byte_t CH_3     = 8'h33;
  localparam byte_t CH_4     = 8'h34;
  localparam byte_t CH_5     = 8'h35;
  localparam byte_t CH_6     = 8'h36;
  localparam byte_t CH_7     = 8'h37;
  localparam byte_t CH_8     = 8'h38;
  localparam byte_t CH_9     = 8'h39;

  localparam len_t LEN_1 = 3'd1;
  localparam len_t LEN_2 = 3'd2;
  localparam len_t LEN_3 = 3'd3;
  localparam len_t LEN_4 = 3'd4;
  localparam len_t LEN_5 = 3'd5;
  localparam len_t LEN_6 = 3'd6;

  // Bytes at or beyond the length must already be zero.
  function automatic key_code_t classify(input byte_t b0, input byte_t b1, input byte_t b2,
                                         input byte_t b3, input byte_t b4, input byte_t b5,
                                         input len_t n);
    byte_t     last;
    logic      esc_csi;
    key_code_t kc;
    esc_csi = (b0 == CH_ESC) && (b1 == CH_LBRK);
    case (n)
      LEN_1:   last = b0;
      LEN_2:   last = b1;
      LEN_3:   last = b2;
      LEN_4:   last = b3;
      LEN_5:   last = b4;
      default: last = b5;
    endcase
    kc = KC_INVALID;
    if (n == 3'd0 || n == 3'd7) begin
      kc = KC_INVALID;
    end else if (b0 == CH_ESC && n == LEN_2 && (b1 == CH_LBRK || b1 == CH_O)) begin
      kc = KC_INCOMPLETE;
    end else if (b0 == CH_ESC && n >= LEN_3 && b1 == CH_LBRK &&
                 !(last inside {[CH_A:CH_Z], CH_TILDE})) begin
      kc = KC_INCOMPLETE;
    end else if (n == LEN_1 && b0 == CH_ESC) begin
      kc = KC_ESC;
    end else if (n == LEN_3 && esc_csi && (b2 inside {CH_A, CH_B, CH_C, CH_D,
                                                      CH_H, CH_F, CH_Z})) begin
      case (b2)
        CH_A:    kc = KC_UP;
        CH_B:    kc = KC_DOWN;
        CH_C:    kc = KC_RIGHT;
        CH_D:    kc = KC_LEFT;
        CH_H:    kc = KC_HOME;
        CH_F:    kc = KC_END;
        default: kc = KC_SHIFT_TAB;
      endcase
    end else if (n == LEN_3 && b0 == CH_ESC && b1 == CH_O &&
                 (b2 inside {[CH_P:CH_S]})) begin
      case (b2)
        CH_P:    kc = KC_F1;
        CH_Q:    kc = KC_F2;
        CH_R:    kc = KC_F3;
        default: kc = KC_F4;
      endcase
    end else if (n >= LEN_5 && esc_csi && b4 == CH_TILDE &&
                 ((b2 == CH_1 && (b3 inside {CH_5, CH_7, CH_8, CH_9})) ||
                  (b2 == CH_2 && (b3 inside {CH_0, CH_1, CH_3, CH_4})))) begin
      case ({b2, b3})
        {CH_1, CH_5}: kc = KC_F5;
        {CH_1, CH_7}: kc = KC_F6;
        {CH_1, CH_8}: kc = KC_F7;
        {CH_1, CH_9}: kc = KC_F8;
        {CH_2, CH_0}: kc = KC_F9;
        {CH_2, CH_1}: kc = KC_F10;
        {CH_2, CH_3}: kc = KC_F11;
        default:      kc = KC_F12;
      endcase
    end else if (n == LEN_4 && b3 == CH_TILDE && (b2 inside {CH_2, CH_3, CH_5, CH_6})) begin
      // Only the third and fourth bytes are compared for the editing keys.
      case (b2)
        CH_2:    kc = KC_INSERT;
        CH_3:    kc = KC_DELETE;
        CH_5:    kc = KC_PGUP;
        default: kc = KC_PGDN;
      endcase
    end else if (n == LEN_6 && esc_csi && b3 == CH_SEMI && b4 == CH_2) begin
      if (b2 == CH_1 && b5 == CH_C) begin
        kc = KC_SHIFT_RIGHT;
      end else if (b2 == CH_1 && b5 == CH_D) begin
        kc = KC_SHIFT_LEFT;
      end else if (b2 == CH_3 && b5 == CH_TILDE) begin
        kc = KC_SHIFT_DELETE;
      end else begin
        kc = KC_INVALID;
      end
    end
    return kc;
  endfunction

endpackage

FILE: rtl/terminal_escape_key_decoder_top.sv
// Top level of the terminal escape-sequence key decoder: input register, classifier, result register.
// A key code passes from the input register through the classifier into the result register.
// Throughput: one item per cycle; the input register and the result register form
// a two-stage pipeline that advances whenever the result register is free or taken.
// Reset: synchronous active-low rst_n empties both stages; payload registers are not reset.
// The block keeps no state between items.
module terminal_escape_key_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tekd_pkg::byte_t     in_byte_0,
  input  tekd_pkg::byte_t     in_byte_1,
  input  tekd_pkg::byte_t     in_byte_2,
  input  tekd_pkg::byte_t     in_byte_3,
  input  tekd_pkg::byte_t     in_byte_4,
  input  tekd_pkg::byte_t     in_byte_5,
  input  tekd_pkg::len_t      in_seq_length,
  output logic                out_valid,
  input  logic                out_ready,
  output tekd_pkg::key_code_t out_key_code
);
  import tekd_pkg::*;

  logic      s1_valid_r;
  byte_t     b_r [6];
  len_t      len_r;
  logic      out_valid_r;
  key_code_t key_r;

  logic      s2_ready;
  logic      s1_ready;
  byte_t     bm [6];
  key_code_t key_nxt;

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Bytes beyond the valid length are zeroed so that they never match a pattern.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      bm[i] = (3'(i) < len_r) ? b_r[i] : 8'h00;
    end
    key_nxt = classify(bm[0], bm[1], bm[2], bm[3], bm[4], bm[5], len_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      b_r[0] <= in_byte_0;
      b_r[1] <= in_byte_1;
      b_r[2] <= in_byte_2;
      b_r[3] <= in_byte_3;
      b_r[4] <= in_byte_4;
      b_r[5] <= in_byte_5;
      len_r  <= in_seq_length;
    end
    if (s1_valid_r && s2_ready) begin
      key_r <= key_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = key_r;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the terminal escape-sequence key decoder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tekd_pkg::*;

  typedef logic [5:0][7:0] seq_t;

  typedef struct {
    seq_t      bytes;
    len_t      len;
    logic      typed;
    key_code_t kc;
  } stim_row_t;

  localparam len_t LEN_NONE = 3'd0;
  localparam len_t LEN_OVER = 3'd7;
  localparam int   NUM_RANDOM = 1900;

  // Pattern tables, element 0 at the right.
  localparam logic [6:0][7:0] ARROW_CH = {CH_Z, CH_F, CH_H, CH_D, CH_C, CH_B, CH_A};
  localparam logic [7:0][15:0] FN_PAIRS = {
    {CH_2, CH_4}, {CH_2, CH_3}, {CH_2, CH_1}, {CH_2, CH_0},
    {CH_1, CH_9}, {CH_1, CH_8}, {CH_1, CH_7}, {CH_1, CH_5}
  };
  localparam logic [3:0][7:0] EDIT_CH = {CH_6, CH_5, CH_3, CH_2};
  localparam logic [2:0][47:0] SHIFT_SEQS = {
    {CH_TILDE, CH_2, CH_SEMI, CH_3, CH_LBRK, CH_ESC},
    {CH_D,     CH_2, CH_SEMI, CH_1, CH_LBRK, CH_ESC},
    {CH_C,     CH_2, CH_SEMI, CH_1, CH_LBRK, CH_ESC}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  byte_t     in_byte_0 = '0;
  byte_t     in_byte_1 = '0;
  byte_t     in_byte_2 = '0;
  byte_t     in_byte_3 = '0;
  byte_t     in_byte_4 = '0;
  byte_t     in_byte_5 = '0;
  len_t      in_seq_length = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  key_code_t out_key_code;

  logic      cur_typed = 1'b0;
  key_code_t cur_kc = KC_INVALID;

  key_code_t key_q[$];
  stim_row_t rows[$];
  key_code_t exp_kc;
  int        errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_keys = 0;
  int        n_incomplete = 0;
  int        n_invalid = 0;

  terminal_escape_key_decoder_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_0     (in_byte_0),
    .in_byte_1     (in_byte_1),
    .in_byte_2     (in_byte_2),
    .in_byte_3     (in_byte_3),
    .in_byte_4     (in_byte_4),
    .in_byte_5     (in_byte_5),
    .in_seq_length (in_seq_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_code  (out_key_code)
  );

  always #5 clk = ~clk;

  function automatic key_code_t predict_key(input seq_t raw, input len_t n);
    seq_t  m;
    byte_t last;
    logic  esc;
    logic  csi;
    m = '0;
    for (int i = 0; i < 6; i++) begin
      if (i < n) m[i] = raw[i];
    end
    esc = (m[0] == CH_ESC);
    csi = esc && (m[1] == CH_LBRK);
    if (n == LEN_NONE || n == LEN_OVER) return KC_INVALID;
    last = m[n - 1];
    // Prefixes that may still grow win over every pattern.
    if (esc) begin
      if (n == LEN_2 && (m[1] == CH_LBRK || m[1] == CH_O)) return KC_INCOMPLETE;
      if (n >= LEN_3 && m[1] == CH_LBRK &&
          !((last >= CH_A && last <= CH_Z) || last == CH_TILDE)) return KC_INCOMPLETE;
    end
    if (n == LEN_1 && esc) return KC_ESC;
    if (n == LEN_3 && csi) begin
      for (int i = 0; i < 7; i++) begin
        if (m[2] == ARROW_CH[i]) return key_code_t'(KC_UP + i);
      end
    end
    if (n == LEN_3 && esc && m[1] == CH_O) begin
      for (int i = 0; i < 4; i++) begin
        if (m[2] == byte_t'(CH_P + i)) return key_code_t'(KC_F1 + i);
      end
    end
    if (n >= LEN_5 && csi && m[4] == CH_TILDE) begin
      for (int i = 0; i < 8; i++) begin
        if ({m[2], m[3]} == FN_PAIRS[i]) return key_code_t'(KC_F5 + i);
      end
    end
    // The editing keys look at the third and fourth bytes only.
    if (n == LEN_4 && m[3] == CH_TILDE) begin
      for (int i = 0; i < 4; i++) begin
        if (m[2] == EDIT_CH[i]) return key_code_t'(KC_INSERT + i);
      end
    end
    if (n == LEN_6) begin
      for (int i = 0; i < 3; i++) begin
        if (m == SHIFT_SEQS[i]) return key_code_t'(KC_SHIFT_RIGHT + i);
      end
    end
    return KC_INVALID;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int        kind;
    int        p;
    for (int i = 0; i < 6; i++) r.bytes[i] = byte_t'($urandom);
    r.typed = 1'b0;
    r.kc = KC_INVALID;
    r.len = len_t'($urandom_range(0, 7));
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      r.bytes[0] = CH_ESC;
      r.bytes[1] = CH_LBRK;
    end
    case (kind)
      0: r.len = LEN_1;
      1: begin
        r.len = LEN_2;
        if ($urandom_range(0, 1) == 1) r.bytes[1] = CH_O;
      end
      2, 3: begin
        r.len = LEN_3;
        r.bytes[2] = ARROW_CH[$urandom_range(0, 6)];
        if ($urandom_range(0, 3) == 0) r.bytes[2] = byte_t'(CH_A + $urandom_range(0, 25));
      end
      4: begin
        r.len = LEN_3;
        r.bytes[1] = CH_O;
        r.bytes[2] = byte_t'(CH_P + $urandom_range(0, 4));
      end
      5, 6, 7: begin
        r.len = (kind == 7) ? LEN_6 : LEN_5;
        {r.bytes[2], r.bytes[3]} = FN_PAIRS[$urandom_range(0, 7)];
        if ($urandom_range(0, 3) == 0) r.bytes[3] = byte_t'(CH_0 + $urandom_range(0, 9));
        r.bytes[4] = CH_TILDE;
        r.bytes[5] = ($urandom_range(0, 1) == 1) ? CH_TILDE
                                                 : byte_t'(CH_A + $urandom_range(0, 25));
      end
      8, 9: begin
        r.len = LEN_4;
        if ($urandom_range(0, 1) == 1) begin
          r.bytes[0] = byte_t'($urandom);
          r.bytes[1] = byte_t'($urandom);
        end
        r.bytes[2] = EDIT_CH[$urandom_range(0, 3)];
        if ($urandom_range(0, 3) == 0) r.bytes[2] = byte_t'(CH_0 + $urandom_range(0, 9));
        r.bytes[3] = CH_TILDE;
      end
      10, 11: begin
        r.len = LEN_6;
        r.bytes = SHIFT_SEQS[$urandom_range(0, 2)];
        if ($urandom_range(0, 3) == 0) r.bytes[2] = ($urandom_range(0, 1) == 1) ? CH_1 : CH_3;
        if ($urandom_range(0, 3) == 0) r.bytes[5] = ARROW_CH[$urandom_range(0, 6)];
      end
      12, 13: begin
        r.len = len_t'($urandom_range(3, 6));
        for (int i = 2; i < 6; i++) r.bytes[i] = byte_t'($urandom_range(8'h20, 8'h7E));
      end
      default: ;
    endcase
    // Break some of the well-formed sequences.
    if (kind < 14) begin
      if ($urandom_range(0, 9) == 0 && r.len != LEN_NONE && r.len != LEN_OVER) begin
        p = $urandom_range(0, r.len - 1);
        r.bytes[p][$urandom_range(0, 7)] ^= 1'b1;
      end
      if ($urandom_range(0, 15) == 0) r.len = len_t'($urandom_range(0, 7));
    end
    return r;
  endfunction

  task automatic add_row(input byte_t b0, input byte_t b1, input byte_t b2, input byte_t b3,
                         input byte_t b4, input byte_t b5, input len_t n,
                         input logic typed, input key_code_t kc);
    stim_row_t r;
    r.bytes = {b5, b4, b3, b2, b1, b0};
    r.len = n;
    r.typed = typed;
    r.kc = kc;
    rows.push_back(r);
  endtask

  // Scoreboard: results leave before new items enter, so pop first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (key_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected key code transfer: expected none, got %0d",
                   $time, out_key_code);
        end else begin
          exp_kc = key_q.pop_front();
          n_checked++;
          if (out_key_code !== exp_kc) begin
            errors++;
            $display("%0t: key code mismatch: expected %0d, got %0d",
                     $time, exp_kc, out_key_code);
          end
          if (exp_kc == KC_INVALID) n_invalid++;
          else if (exp_kc == KC_INCOMPLETE) n_incomplete++;
          else n_keys++;
        end
      end
      if (in_valid && in_ready) begin
        n_sent++;
        if (cur_typed) begin
          key_q.push_back(cur_kc);
        end else begin
          key_q.push_back(predict_key({in_byte_5, in_byte_4, in_byte_3, in_byte_2,
                                       in_byte_1, in_byte_0}, in_seq_length));
        end
      end
    end
  end

  // Output back-pressure, with a calm stretch now and then.
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      stall = ((($time / 5000) % 4) == 3) ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    int gap;
    add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, LEN_NONE, 1'b1, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_A, 8'h00, 8'h00, 8'h00, LEN_OVER, 1'b1, KC_INVALID);
    add_row(CH_ESC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, LEN_1, 1'b1, KC_ESC);
    add_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, LEN_1, 1'b1, KC_INVALID);
    add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, LEN_1, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, 8'h00, 8'h00, 8'h00, 8'h00, LEN_2, 1'b1, KC_INCOMPLETE);
    add_row(CH_ESC, CH_O, 8'h00, 8'h00, 8'h00, 8'h00, LEN_2, 1'b1, KC_INCOMPLETE);
    // Bytes past the length must not matter.
    add_row(CH_ESC, CH_LBRK, CH_A, CH_TILDE, CH_A, CH_A, LEN_2, 1'b1, KC_INCOMPLETE);
    add_row(CH_ESC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, LEN_2, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_1, 8'h00, 8'h00, 8'h00, LEN_3, 1'b1, KC_INCOMPLETE);
    add_row(CH_ESC, CH_LBRK, CH_A, 8'h00, 8'h00, 8'h00, LEN_3, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_Z, 8'h00, 8'h00, 8'h00, LEN_3, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, 8'h45, 8'h00, 8'h00, 8'h00, LEN_3, 1'b1, KC_INVALID);
    add_row(CH_ESC, CH_O, CH_P, 8'h00, 8'h00, 8'h00, LEN_3, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_O, CH_S, 8'h00, 8'h00, 8'h00, LEN_3, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_O, 8'h54, 8'h00, 8'h00, 8'h00, LEN_3, 1'b1, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_1, CH_5, CH_TILDE, 8'h00, LEN_5, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_2, CH_4, CH_TILDE, 8'hFF, LEN_5, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_1, CH_5, CH_TILDE, CH_A, LEN_6, 1'b0, KC_INVALID);
    // Editing keys ignore the first two bytes.
    add_row(8'h00, 8'h00, CH_2, CH_TILDE, 8'h00, 8'h00, LEN_4, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_6, CH_TILDE, 8'hFF, 8'hFF, LEN_4, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_1, CH_SEMI, CH_2, CH_C, LEN_6, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_1, CH_SEMI, CH_2, CH_D, LEN_6, 1'b0, KC_INVALID);
    add_row(CH_ESC, CH_LBRK, CH_3, CH_SEMI, CH_2, CH_TILDE, LEN_6, 1'b0, KC_INVALID);
    for (int i = 0; i < NUM_RANDOM; i++) rows.push_back(random_row());

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int idx = 0; idx < rows.size(); idx++) begin
      gap = (((idx / 128) % 5) == 4) ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid      <= 1'b1;
      in_byte_0     <= rows[idx].bytes[0];
      in_byte_1     <= rows[idx].bytes[1];
      in_byte_2     <= rows[idx].bytes[2];
      in_byte_3     <= rows[idx].bytes[3];
      in_byte_4     <= rows[idx].bytes[4];
      in_byte_5     <= rows[idx].bytes[5];
      in_seq_length <= rows[idx].len;
      cur_typed     <= rows[idx].typed;
      cur_kc        <= rows[idx].kc;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (key_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d byte sequences and checked %0d key codes in order.", n_sent, n_checked);
    $display("Expected results: %0d keys, %0d incomplete, %0d invalid.",
             n_keys, n_incomplete, n_invalid);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d key codes still outstanding.", key_q.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tekd_pkg.sv
rtl/terminal_escape_key_decoder_top.sv
test/tb_top.sv
